/* rtl/lpf_pkg.sv */
// Shared types and constants of the length-prefixed packet FIFO.
package lpf_pkg;

  localparam int unsigned HDR_BYTES        = 2;
  localparam int unsigned MIN_RING         = 3;
  localparam int unsigned RESET_RING_SIZE  = 4096;
  localparam logic [15:0] RESET_MAX_LENGTH = 16'd1024;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int RING_SIZE_W = 13;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int PACKETS_W   = 11;
  localparam int FREE_W      = 13;
  localparam int DROPS_W     = 32;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_DONE       = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_BAD_LENGTH = 3'd2,
    STAT_EMPTY      = 3'd3,
    STAT_CAPACITY   = 3'd4,
    STAT_SWALLOWED  = 3'd5
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RING_SIZE  = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    req_t              req_type;
    logic [BYTE_W-1:0] push_byte;
    logic [LEN_W-1:0]  push_length;
    logic [LEN_W-1:0]  pop_capacity;
  } request_t;

  typedef struct packed {
    status_t              status;
    logic [BYTE_W-1:0]    out_byte;
    logic                 out_last;
    logic [LEN_W-1:0]     front_length;
    logic [PACKETS_W-1:0] packets_waiting;
    logic [FREE_W-1:0]    free_bytes;
    logic [DROPS_W-1:0]   drops;
  } result_t;

endpackage

/* rtl/lpf_stream_if.sv */
// Valid/ready stream channel carrying one payload per transfer.
interface lpf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/length_prefixed_packet_fifo_core.sv */
// Top level of the length-prefixed packet FIFO: sequencer around one byte ring.
//
//  channel   kind        transfer when          carries
//  -------   ---------   --------------------   -------------------------------------
//  request   stream in   valid & ready          req_type, push_byte, push_length, cap
//  result    stream out  valid & ready          status, byte, last, queue snapshot
//  cfg       write port  cfg_write              ring_size / max_packet_length
//
// A middle push byte, a swallowed byte, any refusal, a flush and a no-op finish in
// ST_IDLE; a stored packet's first byte also passes ST_HDR_LO, ST_PAYLOAD (two header
// bytes and the payload byte use the ring's single write port); a popped byte waits in
// ST_POP_RD (registered ring read), the last one, if packets remain, also in ST_FRONT_HI,
// ST_FRONT_LO (next header fetch). The ring store has no reset and needs no clearing;
// rst clears pointers, counts and sequencer. One item is in work at a time. A finished
// result sits in the output register; a new item is taken once that register is free
// or is being drained in the same cycle, so a stalled result side stalls requests.
module length_prefixed_packet_fifo_core #(
  parameter int RING_BYTES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lpf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  lpf_stream_if.sink                       request,
  lpf_stream_if.source                     result
);

  localparam int AW         = $clog2(RING_BYTES);
  localparam int CNT_W      = $clog2(RING_BYTES + 1);
  localparam int PK_W       = $clog2(RING_BYTES / 3 + 1);
  localparam int RESET_SIZE = (RING_BYTES < 4096) ? RING_BYTES : 4096;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_HDR_LO   = 6'b000010,
    ST_PAYLOAD  = 6'b000100,
    ST_POP_RD   = 6'b001000,
    ST_FRONT_HI = 6'b010000,
    ST_FRONT_LO = 6'b100000
  } state_t;

  // Clamp a written ring size into the usable range.
  function automatic logic [CNT_W-1:0] clamp_size(
    input logic [lpf_pkg::RING_SIZE_W-1:0] v
  );
    if (32'(v) < lpf_pkg::MIN_RING) begin
      return CNT_W'(lpf_pkg::MIN_RING);
    end
    if (32'(v) > 32'(RING_BYTES)) begin
      return CNT_W'(RING_BYTES);
    end
    return CNT_W'(v);
  endfunction

  // Advance a ring index by one, wrapping at the current size.
  function automatic logic [AW-1:0] inc_index(input logic [AW-1:0] i,
                                              input logic [CNT_W-1:0] s);
    logic [31:0] sum;
    sum = 32'(i) + 32'd1;
    if (sum >= 32'(s)) begin
      return '0;
    end
    return AW'(sum);
  endfunction

  // Skip the two header bytes of the front packet.
  function automatic logic [AW-1:0] skip_header(input logic [AW-1:0] i,
                                                input logic [CNT_W-1:0] s);
    logic [31:0] sum;
    sum = 32'(i) + lpf_pkg::HDR_BYTES;
    if (sum >= 32'(s)) begin
      sum = sum - 32'(s);
    end
    return AW'(sum);
  endfunction

  // Control and queue state
  state_t                   state, state_next;
  logic [AW-1:0]            wr_index, wr_index_next;
  logic [AW-1:0]            rd_index, rd_index_next;
  logic [CNT_W-1:0]         used, used_next;
  logic [PK_W-1:0]          packets, packets_next;
  logic [31:0]              drops, drops_next;
  logic [15:0]              push_left, push_left_next;
  logic                     push_keeping, push_keeping_next;
  logic [15:0]              pop_left, pop_left_next;
  logic [AW-1:0]            pop_cursor, pop_cursor_next;
  logic [15:0]              front_len, front_len_next;
  logic                     pop_last, pop_last_next;
  logic [CNT_W-1:0]         ring_s;
  logic [15:0]              max_len;
  logic                     out_valid;

  // Payload holding registers
  logic [15:0]              push_len, push_len_next;
  logic [7:0]               byte_hold, byte_hold_next;
  logic [7:0]               hi_hold, hi_hold_next;
  lpf_pkg::result_t         res_payload;

  // Ring port
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [7:0]               ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [7:0]               ram_rdata;

  // Item completion
  logic                     in_fire;
  logic                     finish;
  lpf_pkg::status_t         fin_status;
  logic [7:0]               fin_byte;
  logic                     fin_last;
  logic                     room_ok;
  logic                     release_pkt;
  logic [31:0]              release_len;
  logic [31:0]              free_next;
  lpf_pkg::request_t        req;

  assign req      = request.payload;
  assign request.ready = (state == ST_IDLE) && (!out_valid || result.ready);
  assign in_fire  = request.valid && request.ready;

  assign result.valid   = out_valid;
  assign result.payload = res_payload;

  // A new packet fits when payload plus header is within the free space.
  assign room_ok = (used <= ring_s) &&
                   ((32'(ring_s) - 32'(used)) >= (32'(req.push_length) + lpf_pkg::HDR_BYTES));

  assign release_len = 32'(front_len) + lpf_pkg::HDR_BYTES;

  lpf_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_next        = state;
    wr_index_next     = wr_index;
    rd_index_next     = rd_index;
    used_next         = used;
    packets_next      = packets;
    drops_next        = drops;
    push_left_next    = push_left;
    push_keeping_next = push_keeping;
    pop_left_next     = pop_left;
    pop_cursor_next   = pop_cursor;
    front_len_next    = front_len;
    pop_last_next     = pop_last;
    push_len_next     = push_len;
    byte_hold_next    = byte_hold;
    hi_hold_next      = hi_hold;
    ram_we            = 1'b0;
    ram_waddr         = wr_index;
    ram_wdata         = 8'h00;
    ram_raddr         = pop_cursor;
    finish            = 1'b0;
    fin_status        = lpf_pkg::STAT_DONE;
    fin_byte          = 8'h00;
    fin_last          = 1'b0;
    release_pkt       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (req.req_type)
            lpf_pkg::REQ_PUSH: begin
              if (push_left != 16'd0) begin
                // Middle of a packet: store or swallow the byte
                push_left_next = push_left - 16'd1;
                if (push_keeping) begin
                  ram_we        = 1'b1;
                  ram_wdata     = req.push_byte;
                  wr_index_next = inc_index(wr_index, ring_s);
                  if (push_left == 16'd1) begin
                    packets_next      = packets + PK_W'(1);
                    push_keeping_next = 1'b0;
                    if (packets == '0) begin
                      front_len_next = push_len;
                    end
                  end
                end else begin
                  fin_status = lpf_pkg::STAT_SWALLOWED;
                end
                finish = 1'b1;
              end else if (req.push_length == 16'd0 || req.push_length > max_len) begin
                fin_status        = lpf_pkg::STAT_BAD_LENGTH;
                push_left_next    = (req.push_length == 16'd0) ? 16'd0
                                                               : req.push_length - 16'd1;
                push_keeping_next = 1'b0;
                finish            = 1'b1;
              end else if (!room_ok) begin
                drops_next        = drops + 32'd1;
                fin_status        = lpf_pkg::STAT_FULL;
                push_left_next    = req.push_length - 16'd1;
                push_keeping_next = 1'b0;
                finish            = 1'b1;
              end else begin
                // Reserve room, write the high header byte now
                ram_we            = 1'b1;
                ram_wdata         = req.push_length[15:8];
                wr_index_next     = inc_index(wr_index, ring_s);
                used_next         = CNT_W'(32'(used) + 32'(req.push_length)
                                           + lpf_pkg::HDR_BYTES);
                push_left_next    = req.push_length - 16'd1;
                push_keeping_next = (req.push_length != 16'd1);
                if (req.push_length == 16'd1) begin
                  packets_next = packets + PK_W'(1);
                  if (packets == '0) begin
                    front_len_next = req.push_length;
                  end
                end
                push_len_next  = req.push_length;
                byte_hold_next = req.push_byte;
                state_next     = ST_HDR_LO;
              end
            end
            lpf_pkg::REQ_POP: begin
              if (pop_left == 16'd0) begin
                if (packets == '0) begin
                  fin_status = lpf_pkg::STAT_EMPTY;
                  finish     = 1'b1;
                end else if (req.pop_capacity < front_len) begin
                  fin_status = lpf_pkg::STAT_CAPACITY;
                  finish     = 1'b1;
                end else begin
                  ram_raddr       = skip_header(rd_index, ring_s);
                  pop_cursor_next = inc_index(ram_raddr, ring_s);
                  pop_left_next   = front_len - 16'd1;
                  release_pkt     = (front_len == 16'd1);
                  state_next      = ST_POP_RD;
                end
              end else begin
                ram_raddr       = pop_cursor;
                pop_cursor_next = inc_index(pop_cursor, ring_s);
                pop_left_next   = pop_left - 16'd1;
                release_pkt     = (pop_left == 16'd1);
                state_next      = ST_POP_RD;
              end
              pop_last_next = release_pkt;
              if (release_pkt) begin
                // Free the whole packet once its last byte is read
                rd_index_next = pop_cursor_next;
                used_next     = (32'(used) >= release_len) ? CNT_W'(32'(used) - release_len)
                                                           : '0;
                packets_next  = packets - PK_W'(1);
              end
            end
            lpf_pkg::REQ_FLUSH: begin
              wr_index_next     = '0;
              rd_index_next     = '0;
              used_next         = '0;
              packets_next      = '0;
              push_left_next    = 16'd0;
              push_keeping_next = 1'b0;
              pop_left_next     = 16'd0;
              pop_cursor_next   = '0;
              front_len_next    = 16'd0;
              drops_next        = 32'd0;
              finish            = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_HDR_LO: begin
        ram_we        = 1'b1;
        ram_wdata     = push_len[7:0];
        wr_index_next = inc_index(wr_index, ring_s);
        state_next    = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        ram_we        = 1'b1;
        ram_wdata     = byte_hold;
        wr_index_next = inc_index(wr_index, ring_s);
        finish        = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_POP_RD: begin
        if (pop_last && packets != '0) begin
          // Fetch the next front header before reporting
          byte_hold_next = ram_rdata;
          ram_raddr      = rd_index;
          state_next     = ST_FRONT_HI;
        end else begin
          fin_byte = ram_rdata;
          fin_last = pop_last;
          if (pop_last) begin
            front_len_next = 16'd0;
          end
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FRONT_HI: begin
        hi_hold_next = ram_rdata;
        ram_raddr    = inc_index(rd_index, ring_s);
        state_next   = ST_FRONT_LO;
      end
      ST_FRONT_LO: begin
        front_len_next = {hi_hold, ram_rdata};
        fin_byte       = byte_hold;
        fin_last       = 1'b1;
        finish         = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // The user must let configuration arrive only while idle; the block does not
    // enforce it. A ring size write empties the queue and keeps the drop count
    if (cfg_write && cfg_index == lpf_pkg::CFG_RING_SIZE) begin
      wr_index_next     = '0;
      rd_index_next     = '0;
      used_next         = '0;
      packets_next      = '0;
      push_left_next    = 16'd0;
      push_keeping_next = 1'b0;
      pop_left_next     = 16'd0;
      pop_cursor_next   = '0;
      front_len_next    = 16'd0;
    end
  end

  assign free_next = (used_next > ring_s) ? 32'd0 : 32'(ring_s) - 32'(used_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wr_index     <= '0;
      rd_index     <= '0;
      used         <= '0;
      packets      <= '0;
      drops        <= 32'd0;
      push_left    <= 16'd0;
      push_keeping <= 1'b0;
      pop_left     <= 16'd0;
      pop_cursor   <= '0;
      front_len    <= 16'd0;
      pop_last     <= 1'b0;
      ring_s       <= CNT_W'(RESET_SIZE);
      max_len      <= lpf_pkg::RESET_MAX_LENGTH;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      wr_index     <= wr_index_next;
      rd_index     <= rd_index_next;
      used         <= used_next;
      packets      <= packets_next;
      drops        <= drops_next;
      push_left    <= push_left_next;
      push_keeping <= push_keeping_next;
      pop_left     <= pop_left_next;
      pop_cursor   <= pop_cursor_next;
      front_len    <= front_len_next;
      pop_last     <= pop_last_next;

      // Hold the result until the transfer, load a fresh one on finish
      if (finish) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        if (cfg_index == lpf_pkg::CFG_RING_SIZE) begin
          ring_s <= clamp_size(cfg_data[lpf_pkg::RING_SIZE_W-1:0]);
        end else if (cfg_index == lpf_pkg::CFG_MAX_LENGTH) begin
          max_len <= cfg_data[lpf_pkg::LEN_W-1:0];
        end
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    push_len  <= push_len_next;
    byte_hold <= byte_hold_next;
    hi_hold   <= hi_hold_next;
    if (finish) begin
      res_payload.status          <= fin_status;
      res_payload.out_byte        <= fin_byte;
      res_payload.out_last        <= fin_last;
      res_payload.front_length    <= front_len_next;
      res_payload.packets_waiting <= lpf_pkg::PACKETS_W'(packets_next);
      res_payload.free_bytes      <= lpf_pkg::FREE_W'(free_next);
      res_payload.drops           <= drops_next;
    end
  end

`ifndef SYNTHESIS
  // A pop in progress always has a complete packet behind it
  a_pop_has_packet: assert property (@(posedge clk) disable iff (rst)
    (pop_left != 16'd0) |-> (packets != '0))
    else $error("pop in progress with no queued packet");

  // Reserved bytes never exceed the ring
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= ring_s)
    else $error("reserved bytes exceed ring size");

  // Between items, front length is zero exactly when no complete packet is queued
  a_front_matches: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((packets == '0) == (front_len == 16'd0)))
    else $error("front length out of step with packet count");

  // While an item is in work the output register is empty
  a_busy_out_free: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !out_valid)
    else $error("result pending while an item is in work");
`endif

endmodule

/* rtl/lpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* tb/sv/lpf_result_checker.sv */
// Result checker of the length-prefixed packet FIFO: shadow queue, prediction, comparison.
`timescale 1ns / 100ps

module lpf_result_checker
  import lpf_pkg::*;
#(
  parameter int RING_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   req_valid,
  input  logic                   req_ready,
  input  request_t               req_item,
  input  logic                   res_valid,
  input  logic                   res_ready,
  input  result_t                res_item,
  output int unsigned            results_due,
  output int unsigned            error_count
);

  localparam int unsigned REPORT_LIMIT = 10;

  logic [BYTE_W-1:0]  ring_mem [RING_BYTES];
  int unsigned        wr_at, rd_at, bytes_held, packets_held;
  int unsigned        push_remaining, pop_remaining, pop_at;
  bit                 push_storing;
  logic [DROPS_W-1:0] drop_count;
  int unsigned        ring_cfg, max_len_cfg;
  int unsigned        error_total;
  int unsigned        result_seq;
  result_t            expected_results[$];
  result_t            want;
  bit                 differs;

  initial foreach (ring_mem[i]) ring_mem[i] = '0;

  function automatic int unsigned ring_span();
    if (ring_cfg < MIN_RING) return MIN_RING;
    if (ring_cfg > RING_BYTES) return RING_BYTES;
    return ring_cfg;
  endfunction

  function automatic int unsigned wrap_add(input int unsigned idx, input int unsigned n);
    int unsigned span, sum;
    span = ring_span();
    sum  = idx + n;
    if (sum >= span) sum -= span;
    if (sum >= span) sum = 0;
    return sum;
  endfunction

  function automatic logic [BYTE_W-1:0] byte_at(input int unsigned idx);
    return (idx < RING_BYTES) ? ring_mem[idx] : '0;
  endfunction

  function automatic int unsigned head_length();
    if (packets_held == 0) return 0;
    return {byte_at(rd_at), byte_at(wrap_add(rd_at, 1))};
  endfunction

  task automatic store_byte(input logic [BYTE_W-1:0] b);
    if (wr_at < RING_BYTES) ring_mem[wr_at] = b;
    wr_at = wrap_add(wr_at, 1);
  endtask

  task automatic clear_queue();
    wr_at          = 0;
    rd_at          = 0;
    bytes_held     = 0;
    packets_held   = 0;
    push_remaining = 0;
    push_storing   = 0;
    pop_remaining  = 0;
    pop_at         = 0;
  endtask

  // Advance the shadow queue by one request and queue the result it must produce.
  task automatic predict_result(input request_t rq);
    result_t           rs;
    status_t           st;
    logic [BYTE_W-1:0] ob;
    logic              ol;
    int unsigned       span, head, at;
    span = ring_span();
    st   = STAT_DONE;
    ob   = '0;
    ol   = 1'b0;
    case (rq.req_type)
      REQ_PUSH: begin
        if (push_remaining != 0) begin
          if (push_storing) begin
            store_byte(rq.push_byte);
            push_remaining--;
            if (push_remaining == 0) begin
              packets_held++;
              push_storing = 0;
            end
          end else begin
            push_remaining--;
            st = STAT_SWALLOWED;
          end
        end else if (rq.push_length == 0 || rq.push_length > max_len_cfg) begin
          st             = STAT_BAD_LENGTH;
          push_remaining = (rq.push_length == 0) ? 0 : rq.push_length - 1;
          push_storing   = 0;
        end else if (bytes_held > span || span - bytes_held < rq.push_length + HDR_BYTES) begin
          drop_count++;
          st             = STAT_FULL;
          push_remaining = rq.push_length - 1;
          push_storing   = 0;
        end else begin
          // big-endian header, then the first payload byte
          store_byte(rq.push_length[15:8]);
          store_byte(rq.push_length[7:0]);
          store_byte(rq.push_byte);
          bytes_held     += rq.push_length + HDR_BYTES;
          push_remaining = rq.push_length - 1;
          push_storing   = (push_remaining != 0);
          if (push_remaining == 0) packets_held++;
        end
      end
      REQ_POP: begin
        if (pop_remaining == 0) begin
          head = head_length();
          if (packets_held == 0) begin
            st = STAT_EMPTY;
          end else if (rq.pop_capacity < head) begin
            st = STAT_CAPACITY;
          end else begin
            at            = wrap_add(rd_at, HDR_BYTES);
            ob            = byte_at(at);
            pop_at        = wrap_add(at, 1);
            pop_remaining = head;
          end
        end else begin
          ob     = byte_at(pop_at);
          pop_at = wrap_add(pop_at, 1);
        end
        if (st == STAT_DONE && pop_remaining != 0) begin
          pop_remaining--;
          if (pop_remaining == 0) begin
            // release header and payload of the front packet
            head       = head_length();
            ol         = 1'b1;
            rd_at      = wrap_add(rd_at, 1);
            rd_at      = wrap_add(rd_at, head + 1);
            bytes_held = (bytes_held >= head + HDR_BYTES) ? bytes_held - (head + HDR_BYTES) : 0;
            if (packets_held != 0) packets_held--;
          end
        end
      end
      REQ_FLUSH: begin
        clear_queue();
        drop_count = '0;
      end
      default: ;
    endcase
    rs.status          = st;
    rs.out_byte        = ob;
    rs.out_last        = ol;
    rs.front_length    = LEN_W'(head_length());
    rs.packets_waiting = PACKETS_W'(packets_held);
    rs.free_bytes      = FREE_W'((bytes_held > span) ? 0 : span - bytes_held);
    rs.drops           = drop_count;
    expected_results.push_back(rs);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_queue();
      drop_count  = '0;
      ring_cfg    = RESET_RING_SIZE;
      max_len_cfg = RESET_MAX_LENGTH;
      error_total = 0;
      result_seq  = 0;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_RING_SIZE) begin
          ring_cfg = cfg_data & 16'h1FFF;
          clear_queue();
        end else begin
          max_len_cfg = cfg_data;
        end
      end
      if (req_valid && req_ready) predict_result(req_item);
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          if (error_total < REPORT_LIMIT)
            $display("%0t: result %0d arrived with nothing expected", $time, result_seq);
          error_total++;
        end else begin
          want    = expected_results.pop_front();
          differs = (res_item.status != want.status)
                 || (res_item.out_byte != want.out_byte)
                 || (res_item.out_last != want.out_last)
                 || (res_item.front_length != want.front_length)
                 || (res_item.packets_waiting != want.packets_waiting)
                 || (res_item.free_bytes != want.free_bytes)
                 || (res_item.drops != want.drops);
          if (differs) begin
            if (error_total < REPORT_LIMIT) begin
              $display("%0t: result %0d mismatch (expected/actual) status %0d/%0d byte %0h/%0h last %0d/%0d",
                       $time, result_seq, want.status, res_item.status, want.out_byte,
                       res_item.out_byte, want.out_last, res_item.out_last);
              $display("  front %0d/%0d packets %0d/%0d free %0d/%0d drops %0d/%0d",
                       want.front_length, res_item.front_length, want.packets_waiting,
                       res_item.packets_waiting, want.free_bytes, res_item.free_bytes,
                       want.drops, res_item.drops);
            end
            error_total++;
          end
        end
        result_seq++;
      end
    end
    results_due <= expected_results.size();
    error_count <= error_total;
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top of the length-prefixed packet FIFO: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import lpf_pkg::*;

  localparam int          RING_BYTES        = 4096;
  localparam int unsigned LONG_STALL_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT    = 2000;
  localparam int unsigned PHASES            = 8;
  localparam int unsigned PHASE_ITEMS       = 235;

  // Register settings per random phase: extremes, a ring smaller than the
  // longest packet, masked and clamped ring sizes, then a calm closing phase.
  localparam logic [15:0] RING_SET [PHASES] = '{16'hFFFF, 16'd5, 16'd64, 16'd0,
                                                16'd300, 16'd4096, 16'd33, 16'd128};
  localparam logic [15:0] MAX_SET  [PHASES] = '{16'hFFFF, 16'd3, 16'd40, 16'd1,
                                                16'd100, 16'd1024, 16'hFFFF, 16'd60};
  localparam int unsigned POP_PCT  [PHASES] = '{30, 45, 40, 45, 40, 35, 40, 45};

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            results_due;
  int unsigned            error_count;
  int unsigned            quiet_cycles;
  bit                     calm;
  bit                     long_stall_req;

  lpf_stream_if #(.payload_t(request_t)) request_ch ();
  lpf_stream_if #(.payload_t(result_t))  result_ch ();

  length_prefixed_packet_fifo_core #(.RING_BYTES(RING_BYTES)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request_ch),
    .result    (result_ch)
  );

  lpf_result_checker #(.RING_BYTES(RING_BYTES)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (request_ch.valid),
    .req_ready   (request_ch.ready),
    .req_item    (request_ch.payload),
    .res_valid   (result_ch.valid),
    .res_ready   (result_ch.ready),
    .res_item    (result_ch.payload),
    .results_due (results_due),
    .error_count (error_count)
  );

  always #5 clk = ~clk;

  function automatic request_t make_req(input req_t kind, input logic [7:0] b,
                                        input logic [15:0] len, input logic [15:0] cap);
    request_t r;
    r.req_type     = kind;
    r.push_byte    = b;
    r.push_length  = len;
    r.pop_capacity = cap;
    return r;
  endfunction

  // Mostly a capacity that always fits; sometimes random or tiny to hit the
  // capacity-too-small refusal.
  function automatic logic [15:0] pick_capacity();
    int unsigned p;
    p = $urandom_range(99, 0);
    if (p < 70) return 16'hFFFF;
    if (p < 85) return 16'($urandom);
    return 16'($urandom_range(8, 0));
  endfunction

  // Mostly short packets, some long ones, a few zero or over-limit lengths.
  // Over-limit lengths only where the limit is small, so the swallowed tail stays short.
  function automatic int unsigned pick_length(input int unsigned len_cfg);
    int unsigned p, top_len;
    p = $urandom_range(99, 0);
    if (p < 3) return 0;
    if (p < 10 && len_cfg <= 100) return len_cfg + $urandom_range(3, 1);
    top_len = (p < 15) ? 300 : 16;
    if (top_len > len_cfg) top_len = len_cfg;
    return $urandom_range(top_len, 1);
  endfunction

  // Offer one request and hold it until the transfer; sometimes idle a random burst first.
  task automatic send_item(input request_t r);
    if (!calm && $urandom_range(99, 0) < 15) begin
      request_ch.valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    request_ch.valid   <= 1'b1;
    request_ch.payload <= r;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold off until every expected result has been taken.
  task automatic wait_results_done();
    request_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Raise the write for one cycle per call; the caller lowers cfg_write after the last.
  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Random traffic: whole packets with random content and pops interleaved,
  // plus pop bursts, flushes, no-ops and packets cut short.
  task automatic run_traffic(input int unsigned n_items, input int unsigned pop_pct,
                             input int unsigned len_cfg);
    int unsigned sent, pick, len, stop_at, k;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99, 0);
      if (pick < pop_pct) begin
        repeat ($urandom_range(12, 1)) begin
          send_item(make_req(REQ_POP, 8'($urandom), 16'($urandom), pick_capacity()));
          sent++;
        end
      end else if (pick < 94) begin
        len     = pick_length(len_cfg);
        stop_at = ($urandom_range(99, 0) < 4) ? $urandom_range(len, 0) : len;
        send_item(make_req(REQ_PUSH, 8'($urandom), 16'(len), 16'($urandom)));
        sent++;
        for (k = 1; k < stop_at; k++) begin
          if ($urandom_range(3, 0) == 0) begin
            send_item(make_req(REQ_POP, 8'($urandom), 16'($urandom), pick_capacity()));
            sent++;
          end
          // the length field is ignored mid-packet; fill it with noise
          send_item(make_req(REQ_PUSH, 8'($urandom), 16'($urandom), 16'($urandom)));
          sent++;
        end
      end else if (pick < 97) begin
        send_item(make_req(REQ_NOP, 8'($urandom), 16'($urandom), 16'($urandom)));
      end else begin
        send_item(make_req(REQ_FLUSH, 8'($urandom), 16'($urandom), 16'($urandom)));
        sent++;
      end
    end
  endtask

  // Result side: random stall bursts, a long hold-off on request, none when calm.
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_stall_req) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall_req = 1'b0;
      end else if (!calm && $urandom_range(99, 0) < 30) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 1)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (rst || cfg_write || (request_ch.valid && request_ch.ready)
        || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_write          <= 1'b0;
    cfg_index          <= CFG_RING_SIZE;
    cfg_data           <= '0;
    request_ch.valid   <= 1'b0;
    request_ch.payload <= '0;
    calm               = 1'b0;
    long_stall_req     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: empty pop, zero and oversized lengths,
    // byte extremes, capacity refusal, no-op, flush in the middle of a packet.
    send_item(make_req(REQ_POP,   8'h00, 16'h0000, 16'h0000));
    send_item(make_req(REQ_PUSH,  8'h00, 16'h0000, 16'h0000));
    send_item(make_req(REQ_PUSH,  8'h00, 16'hFFFF, 16'h0000));
    send_item(make_req(REQ_FLUSH, 8'h00, 16'h0000, 16'h0000));
    send_item(make_req(REQ_PUSH,  8'hFF, 16'd1,    16'hFFFF));
    send_item(make_req(REQ_PUSH,  8'h00, 16'd3,    16'h0000));
    send_item(make_req(REQ_PUSH,  8'hA5, 16'hFFFF, 16'h0000));
    send_item(make_req(REQ_PUSH,  8'h5A, 16'h0000, 16'h0000));
    send_item(make_req(REQ_POP,   8'h00, 16'h0000, 16'h0000));
    send_item(make_req(REQ_POP,   8'h00, 16'h0000, 16'd1));
    send_item(make_req(REQ_POP,   8'h00, 16'h0000, 16'hFFFF));
    send_item(make_req(REQ_POP,   8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_req(REQ_POP,   8'h00, 16'h0000, 16'h0000));
    send_item(make_req(REQ_POP,   8'h00, 16'h0000, 16'hFFFF));
    send_item(make_req(REQ_NOP,   8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_req(REQ_PUSH,  8'h11, 16'd2,    16'h0000));
    send_item(make_req(REQ_FLUSH, 8'h00, 16'h0000, 16'h0000));
    send_item(make_req(REQ_PUSH,  8'h22, 16'd1,    16'h0000));

    // Smallest ring and limit: exact fit, no room, over-limit with a swallowed byte.
    wait_results_done();
    write_reg(CFG_RING_SIZE, 16'd3);
    write_reg(CFG_MAX_LENGTH, 16'd1);
    cfg_write <= 1'b0;
    send_item(make_req(REQ_PUSH, 8'h33, 16'd1, 16'h0000));
    send_item(make_req(REQ_PUSH, 8'h44, 16'd1, 16'h0000));
    send_item(make_req(REQ_PUSH, 8'h55, 16'd2, 16'h0000));
    send_item(make_req(REQ_PUSH, 8'h66, 16'd0, 16'h0000));
    send_item(make_req(REQ_POP,  8'h00, 16'h0000, 16'd1));

    // Raise the limit only: a packet longer than the ring is dropped and swallowed.
    wait_results_done();
    write_reg(CFG_MAX_LENGTH, 16'd1024);
    cfg_write <= 1'b0;
    send_item(make_req(REQ_PUSH, 8'h77, 16'd2, 16'h0000));
    send_item(make_req(REQ_PUSH, 8'h88, 16'd0, 16'h0000));

    // Random phases, each split by a pause until all results are in.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_results_done();
      write_reg(CFG_RING_SIZE, RING_SET[ph]);
      write_reg(CFG_MAX_LENGTH, MAX_SET[ph]);
      cfg_write <= 1'b0;
      if (ph == PHASES - 1) calm = 1'b1;
      run_traffic(PHASE_ITEMS / 2, POP_PCT[ph], MAX_SET[ph]);
      wait_results_done();
      // hold results off for a long stretch while requests keep coming
      if (ph == 2) long_stall_req = 1'b1;
      run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2, POP_PCT[ph], MAX_SET[ph]);
    end

    wait_results_done();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
